[design/pcah_pkg.sv]
// Shared types, codes and arithmetic helpers for the HSL pixel colour adjust block.
// No dependencies; imported by the top level, the scoreboard and the testbench.
package pcah_pkg;

  localparam logic [1:0] OP_PIXEL         = 2'd0;
  localparam logic [1:0] OP_LOAD_BRIGHT   = 2'd1;
  localparam logic [1:0] OP_LOAD_CONTRAST = 2'd2;
  localparam logic [1:0] OP_UNUSED        = 2'd3;

  localparam logic [2:0] REG_RED_GAIN   = 3'd0;
  localparam logic [2:0] REG_GREEN_GAIN = 3'd1;
  localparam logic [2:0] REG_BLUE_GAIN  = 3'd2;
  localparam logic [2:0] REG_HUE        = 3'd3;
  localparam logic [2:0] REG_SAT        = 3'd4;
  localparam logic [2:0] REG_LIGHT      = 3'd5;
  localparam logic [2:0] REG_MODE       = 3'd6;
  localparam logic [2:0] REG_SPARE      = 3'd7;

  // floor(x / 100) for any 16-bit x: multiply by ceil(2^23 / 100), keep the top bits
  localparam logic [16:0] RECIP_100 = 17'd83887;
  // floor(y / 21675) for any 23-bit y: multiply by ceil(2^38 / 21675), keep bits 38 up
  localparam logic [23:0] HSL_RECIP = 24'd12681796;
  // half of the HSL back-conversion divisor (65025 * 2 / 6), for round-half-up
  localparam logic [22:0] HSL_BIAS  = 23'd10837;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] ir;
    logic [7:0] ig;
    logic [7:0] ib;
    logic [7:0] ia;
    logic [7:0] idx;
    logic [7:0] tval;
  } item_t;

  // Percent scale: x / 100, clamped to 255.
  function automatic logic [7:0] div100_clamp(input logic [15:0] x);
    logic [32:0] p;
    logic [9:0]  q;
    p = 33'(x) * 33'(RECIP_100);
    q = p[32:23];
    return (q > 10'd255) ? 8'd255 : q[7:0];
  endfunction

  // One restoring step against a 9-bit divisor: {quotient bit, new remainder}.
  function automatic logic [17:0] vdiv_step(input logic [16:0] rem, input logic [8:0] den,
                                            input int unsigned sh);
    logic [17:0] sub;
    sub = {1'b0, rem} - ({9'd0, den} << sh);
    return sub[17] ? {1'b0, rem} : {1'b1, sub[16:0]};
  endfunction

endpackage

[design/pcah_if.sv]
// Valid/ready channels for pixel and table-load requests in, adjusted pixels out.
// No dependencies.
interface pcah_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;
  logic [7:0] in_alpha;
  logic [7:0] table_index;
  logic [7:0] table_value;

  modport source (output valid, opcode, in_red, in_green, in_blue, in_alpha,
                  table_index, table_value, input ready);
  modport sink (input valid, opcode, in_red, in_green, in_blue, in_alpha,
                table_index, table_value, output ready);
endinterface

interface pcah_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] out_alpha;

  modport source (output valid, out_red, out_green, out_blue, out_alpha, input ready);
  modport sink (input valid, out_red, out_green, out_blue, out_alpha, output ready);
endinterface

[design/pixel_color_adjust_hsl.sv]
// Each accepted request moves through the stage registers in order; stage 18 is the output register.
// Throughput: one request per clock; every stage holds on back-pressure and fills bubbles.
// Saturation and hue use a 4-stage restoring divider (two quotient bits per stage);
// the HSL back-conversion divides by a constant through a reciprocal multiply.
// Reset clears stage valid bits, presets configuration; lookup tables undefined until loaded.
// Depends on pcah_pkg and the interfaces in pcah_if.sv.
module pixel_color_adjust_hsl import pcah_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  pcah_in_if.sink     pixel_in,
  pcah_out_if.source  pixel_out
);

  localparam int NS   = 19;
  localparam int LAST = NS - 1;

  logic [7:0] red_gain, green_gain, blue_gain, hue_amount, sat_pct, light_pct, mode_flags;

  always_ff @(posedge clk) begin
    if (rst) begin
      red_gain   <= 8'd0;
      green_gain <= 8'd0;
      blue_gain  <= 8'd0;
      hue_amount <= 8'd0;
      sat_pct    <= 8'd100;
      light_pct  <= 8'd100;
      mode_flags <= 8'd240;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RED_GAIN:   red_gain   <= cfg_data;
        REG_GREEN_GAIN: green_gain <= cfg_data;
        REG_BLUE_GAIN:  blue_gain  <= cfg_data;
        REG_HUE:        hue_amount <= cfg_data;
        REG_SAT:        sat_pct    <= cfg_data;
        REG_LIGHT:      light_pct  <= cfg_data;
        REG_MODE:       mode_flags <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- stage control ----------------
  logic [NS-1:0] v, adv;
  item_t itm [NS];

  always_comb begin
    adv[LAST] = !v[LAST] || pixel_out.ready;
    for (int k = LAST - 1; k >= 0; k--) adv[k] = !v[k] || adv[k+1];
  end

  assign pixel_in.ready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) v[0] <= pixel_in.valid;
      for (int k = 1; k < NS; k++) begin
        // drop table loads and unused opcodes once the tables are behind them
        if (adv[k]) v[k] <= v[k-1] && (k != 5 || itm[4].op == OP_PIXEL);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) itm[0] <= '{op: pixel_in.opcode, ir: pixel_in.in_red, ig: pixel_in.in_green,
                           ib: pixel_in.in_blue, ia: pixel_in.in_alpha,
                           idx: pixel_in.table_index, tval: pixel_in.table_value};
    for (int k = 1; k < NS; k++) begin
      if (adv[k]) itm[k] <= itm[k-1];
    end
  end

  // ---------------- stages 1..4: negate, gain, brightness, contrast ----------------
  logic [7:0]  in_c [3];
  logic [7:0]  gain_reg [3];
  logic [15:0] prod1 [3];
  logic        zero1 [3];
  logic [7:0]  c2 [3];
  logic [7:0]  bq [3];
  logic [7:0]  cq [3];

  assign in_c[0] = itm[0].ir;
  assign in_c[1] = itm[0].ig;
  assign in_c[2] = itm[0].ib;
  assign gain_reg[0] = red_gain;
  assign gain_reg[1] = green_gain;
  assign gain_reg[2] = blue_gain;

  for (genvar ch = 0; ch < 3; ch++) begin : g_front
    logic [7:0]        c;
    logic signed [8:0] f;
    logic [7:0]        bmem [256];
    logic [7:0]        cmem [256];

    always_comb begin
      c = mode_flags[ch] ? (8'd255 - in_c[ch]) : in_c[ch];
      f = $signed({gain_reg[ch][7], gain_reg[ch]}) + 9'sd100;
    end

    always_ff @(posedge clk) begin
      if (adv[1]) begin
        prod1[ch] <= 16'(c) * 16'(f[7:0]);
        zero1[ch] <= f[8] || (f == 9'sd0);
      end
      if (adv[2]) c2[ch] <= zero1[ch] ? 8'd0 : div100_clamp(prod1[ch]);
    end

    always_ff @(posedge clk) begin
      if (adv[3]) begin
        bq[ch] <= bmem[c2[ch]];
        if (v[2] && itm[2].op == OP_LOAD_BRIGHT) bmem[itm[2].idx] <= itm[2].tval;
      end
    end

    always_ff @(posedge clk) begin
      if (adv[4]) begin
        cq[ch] <= cmem[bq[ch]];
        if (v[3] && itm[3].op == OP_LOAD_CONTRAST) cmem[itm[3].idx] <= itm[3].tval;
      end
    end
  end

  // ---------------- stage 5: HSL forward terms ----------------
  logic [7:0]         mx, mn, d5, den5;
  logic [8:0]         sum5;
  logic [9:0]         lsum;
  logic               achrom;
  logic signed [11:0] nn;
  logic [16:0]        snum5, hnum5;
  logic [8:0]         sden5, hden5;
  logic [7:0]         lit5;

  always_comb begin
    mx = (cq[0] > cq[1]) ? cq[0] : cq[1];
    if (cq[2] > mx) mx = cq[2];
    mn = (cq[0] < cq[1]) ? cq[0] : cq[1];
    if (cq[2] < mn) mn = cq[2];
    sum5   = 9'(mx) + 9'(mn);
    lsum   = 10'(sum5) + 10'd1;
    d5     = mx - mn;
    den5   = (sum5 < 9'd256) ? sum5[7:0] : 8'(9'd511 - sum5);
    achrom = (mx == mn);
    if (cq[0] == mx)
      nn = $signed({4'd0, cq[1]}) - $signed({4'd0, cq[2]});
    else if (cq[1] == mx)
      nn = $signed({3'd0, d5, 1'b0}) + $signed({4'd0, cq[2]}) - $signed({4'd0, cq[0]});
    else
      nn = $signed({2'd0, d5, 2'd0}) + $signed({4'd0, cq[0]}) - $signed({4'd0, cq[1]});
    if (nn < 12'sd0) nn = nn + $signed({4'd0, d5}) * 12'sd6;
  end

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      lit5  <= lsum[8:1];
      snum5 <= achrom ? 17'd0 : 17'(d5) * 17'd510 + 17'(den5);
      sden5 <= achrom ? 9'd1 : {den5, 1'b0};
      hnum5 <= achrom ? 17'd0 : 17'(nn[10:0]) * 17'd85 + 17'(d5);
      hden5 <= achrom ? 9'd1 : {d5, 1'b0};
    end
  end

  // ---------------- stages 6..9: saturation and hue division ----------------
  logic [16:0] srem [4];
  logic [16:0] hrem [4];
  logic [8:0]  sden [4];
  logic [8:0]  hden [4];
  logic [7:0]  sq [4];
  logic [7:0]  hq [4];
  logic [7:0]  litd [4];

  for (genvar j = 0; j < 4; j++) begin : g_vdiv
    logic [16:0] srem_in, hrem_in;
    logic [8:0]  sden_in, hden_in;
    logic [7:0]  sq_in, hq_in, lit_in;
    logic [17:0] s1, s2, h1, h2;

    if (j == 0) begin : g_first
      assign srem_in = snum5;
      assign hrem_in = hnum5;
      assign sden_in = sden5;
      assign hden_in = hden5;
      assign sq_in   = 8'd0;
      assign hq_in   = 8'd0;
      assign lit_in  = lit5;
    end else begin : g_next
      assign srem_in = srem[j-1];
      assign hrem_in = hrem[j-1];
      assign sden_in = sden[j-1];
      assign hden_in = hden[j-1];
      assign sq_in   = sq[j-1];
      assign hq_in   = hq[j-1];
      assign lit_in  = litd[j-1];
    end

    always_comb begin
      s1 = vdiv_step(srem_in, sden_in, 7 - 2 * j);
      s2 = vdiv_step(s1[16:0], sden_in, 6 - 2 * j);
      h1 = vdiv_step(hrem_in, hden_in, 7 - 2 * j);
      h2 = vdiv_step(h1[16:0], hden_in, 6 - 2 * j);
    end

    always_ff @(posedge clk) begin
      if (adv[6+j]) begin
        srem[j] <= s2[16:0];
        hrem[j] <= h2[16:0];
        sden[j] <= sden_in;
        hden[j] <= hden_in;
        sq[j]   <= {sq_in[5:0], s1[17], s2[17]};
        hq[j]   <= {hq_in[5:0], h1[17], h2[17]};
        litd[j] <= lit_in;
      end
    end
  end

  // ---------------- stages 10..12: adjust and HSL back terms ----------------
  logic [7:0]  hue10, hue11, hue12, sat11, lit11, lit12;
  logic [15:0] sp10, lp10;
  logic        sat0_12;
  logic [16:0] m1_12, m2_12;
  logic [15:0] ls;
  logic [17:0] m2c, m1c;

  always_ff @(posedge clk) begin
    if (adv[10]) begin
      hue10 <= mode_flags[3] ? hue_amount : hq[3] + hue_amount;
      sp10  <= 16'(sq[3]) * 16'(sat_pct);
      lp10  <= 16'(litd[3]) * 16'(light_pct);
    end
    if (adv[11]) begin
      hue11 <= hue10;
      sat11 <= div100_clamp(sp10);
      lit11 <= div100_clamp(lp10);
    end
  end

  always_comb begin
    ls  = 16'(lit11) * 16'(sat11);
    m2c = (lit11 < 8'd128) ? 18'(lit11) * 18'd255 + 18'(ls)
                           : 18'(lit11) * 18'd255 + 18'(sat11) * 18'd255 - 18'(ls);
    m1c = 18'(lit11) * 18'd510 - m2c;
  end

  always_ff @(posedge clk) begin
    if (adv[12]) begin
      hue12   <= hue11;
      lit12   <= lit11;
      sat0_12 <= (sat11 == 8'd0);
      m1_12   <= m1c[16:0];
      m2_12   <= m2c[16:0];
    end
  end

  // ---------------- stages 13..17: per-channel numerator and constant division ----------------
  logic [16:0] diff12;
  logic [7:0]  lit_e [5];
  logic        sat0_e [5];

  assign diff12 = m2_12 - m1_12;

  always_ff @(posedge clk) begin
    if (adv[13]) begin
      lit_e[0]  <= lit12;
      sat0_e[0] <= sat0_12;
    end
    for (int j = 1; j < 5; j++) begin
      if (adv[13+j]) begin
        lit_e[j]  <= lit_e[j-1];
        sat0_e[j] <= sat0_e[j-1];
      end
    end
  end

  logic [7:0] hres [3];

  for (genvar ch = 0; ch < 3; ch++) begin : g_back
    localparam int HUE_OFS = 85 - 85 * ch;
    logic signed [9:0] h, hw;
    logic [7:0]        hwu;
    logic [5:0]        hh;
    logic [24:0]       x;
    logic [22:0]       cnum;
    logic [45:0]       cprod;
    logic [7:0]        cqt [3];

    always_comb begin
      h = $signed({2'b00, hue12}) + $signed(10'(HUE_OFS));
      hw = h;
      if (h > 10'sd255) hw = h - 10'sd255;
      else if (h < 10'sd0) hw = h + 10'sd255;
      hwu = hw[7:0];
      hh  = 6'd0;
      if (hwu <= 8'd42) hh = hwu[5:0];
      else if (hwu >= 8'd128 && hwu < 8'd170) hh = 6'(8'd170 - hwu);
      if (hwu > 8'd42 && hwu <= 8'd127)
        x = 25'(m2_12) * 25'd85;
      else
        x = 25'(m1_12) * 25'd85 + ((25'(hh) * 25'(diff12)) << 1);
    end

    // divide by 21675 as a multiply by its reciprocal, then hold the quotient
    always_ff @(posedge clk) begin
      if (adv[13]) cnum   <= x[22:0] + HSL_BIAS;
      if (adv[14]) cprod  <= 46'(cnum) * 46'(HSL_RECIP);
      if (adv[15]) cqt[0] <= cprod[45:38];
      if (adv[16]) cqt[1] <= cqt[0];
      if (adv[17]) cqt[2] <= cqt[1];
    end

    assign hres[ch] = sat0_e[4] ? lit_e[4] : cqt[2];
  end

  // ---------------- stage 18: channel select and output register ----------------
  logic [7:0] o_red, o_green, o_blue, o_alpha;

  always_ff @(posedge clk) begin
    if (adv[LAST]) begin
      o_red   <= mode_flags[4] ? hres[0] : itm[LAST-1].ir;
      o_green <= mode_flags[5] ? hres[1] : itm[LAST-1].ig;
      o_blue  <= mode_flags[6] ? hres[2] : itm[LAST-1].ib;
      o_alpha <= mode_flags[7] ? itm[LAST-1].ia : 8'd255;
    end
  end

  assign pixel_out.valid     = v[LAST];
  assign pixel_out.out_red   = o_red;
  assign pixel_out.out_green = o_green;
  assign pixel_out.out_blue  = o_blue;
  assign pixel_out.out_alpha = o_alpha;

endmodule

[design/pcah_checker.sv]
// Port-level checks for the HSL pixel colour adjust block, bound to the top level.
// Depends only on the top level's ports.
module pcah_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue,
  input logic [7:0] out_alpha
);

  // a result held back must stay put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_red) && $stable(out_green)
                                && $stable(out_blue) && $stable(out_alpha))
    else $error("result changed while stalled");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid straight after reset");

  // input back-pressure only arises from a full pipe stalled at the output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output back-pressure");

  // a full, stalled pipe still holds a valid result in the next cycle
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready && !out_ready |=> out_valid)
    else $error("pipeline lost a result during a stall");

endmodule

bind pixel_color_adjust_hsl pcah_checker u_pcah_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (pixel_in.valid),
  .in_ready  (pixel_in.ready),
  .out_valid (pixel_out.valid),
  .out_ready (pixel_out.ready),
  .out_red   (pixel_out.out_red),
  .out_green (pixel_out.out_green),
  .out_blue  (pixel_out.out_blue),
  .out_alpha (pixel_out.out_alpha)
);

[dv/pcah_checker.sv]
// Scoreboard for the HSL pixel colour adjust block: predicts each pixel request and
// compares the adjusted pixels in order. Depends on pcah_pkg and the channels in pcah_if.sv.
`timescale 1ns / 100ps
module pcah_scoreboard import pcah_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data,
  pcah_in_if    pix_in,
  pcah_out_if   pix_out,
  output int    errors,
  output int    pending
);

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
  } rgba_t;

  logic [7:0] bright_lut [256];
  logic [7:0] contrast_lut [256];
  logic [7:0] red_gain, green_gain, blue_gain, hue_amt, sat_pct, light_pct, mode;
  rgba_t      adjusted_q[$];

  assign pending = adjusted_q.size();

  function automatic int apply_gain(int c, logic [7:0] pct);
    int f, v;
    f = int'($signed(pct)) + 100;
    if (f <= 0) return 0;
    v = (c * f) / 100;
    return (v > 255) ? 255 : v;
  endfunction

  function automatic int hsl_to_chan(longint m1, longint m2, int h);
    longint num;
    if (h > 255) h -= 255;
    else if (h < 0) h += 255;
    if (h <= 42) num = 2 * (85 * m1 + 2 * longint'(h) * (m2 - m1)) + 21675;
    else if (h <= 127) return int'((2 * m2 + 255) / 510) & 255;
    else if (h < 170) num = 2 * (85 * m1 + 2 * longint'(170 - h) * (m2 - m1)) + 21675;
    else return int'((2 * m1 + 255) / 510) & 255;
    if (num < 0) num = 0;
    return int'(num / 43350) & 255;
  endfunction

  function automatic rgba_t adjust_pixel(item_t it);
    int r, g, b, mx, mn, sum, hue, sat, lit, d, den, n;
    longint l, s, m1, m2;
    rgba_t res, hsl;
    r = mode[0] ? 255 - it.ir : it.ir;
    g = mode[1] ? 255 - it.ig : it.ig;
    b = mode[2] ? 255 - it.ib : it.ib;
    r = contrast_lut[bright_lut[apply_gain(r, red_gain)]];
    g = contrast_lut[bright_lut[apply_gain(g, green_gain)]];
    b = contrast_lut[bright_lut[apply_gain(b, blue_gain)]];
    mx = (r > g) ? r : g; if (b > mx) mx = b;
    mn = (r < g) ? r : g; if (b < mn) mn = b;
    sum = mx + mn;
    lit = (sum + 1) >> 1;
    sat = 0;
    hue = 0;
    if (mx != mn) begin
      d = mx - mn;
      den = (sum < 256) ? sum : 511 - sum;
      sat = (510 * d + den) / (2 * den);
      if (r == mx) n = g - b;
      else if (g == mx) n = 2 * d + b - r;
      else n = 4 * d + r - g;
      if (n < 0) n += 6 * d;
      hue = ((85 * n + d) / (2 * d)) & 255;
    end
    hue = mode[3] ? int'(hue_amt) : ((hue + hue_amt) & 255);
    sat = (sat * sat_pct) / 100; if (sat > 255) sat = 255;
    lit = (lit * light_pct) / 100; if (lit > 255) lit = 255;
    if (sat == 0) begin
      hsl.r = lit[7:0]; hsl.g = lit[7:0]; hsl.b = lit[7:0];
    end else begin
      l = lit;
      s = sat;
      m2 = (lit < 128) ? l * (255 + s) : 255 * l + 255 * s - l * s;
      m1 = 510 * l - m2;
      hsl.r = 8'(hsl_to_chan(m1, m2, hue + 85));
      hsl.g = 8'(hsl_to_chan(m1, m2, hue));
      hsl.b = 8'(hsl_to_chan(m1, m2, hue - 85));
    end
    res.r = mode[4] ? hsl.r : it.ir;
    res.g = mode[5] ? hsl.g : it.ig;
    res.b = mode[6] ? hsl.b : it.ib;
    res.a = mode[7] ? it.ia : 8'd255;
    return res;
  endfunction

  always @(posedge clk) begin
    item_t it;
    rgba_t want, got;
    if (rst) begin
      red_gain <= 8'd0; green_gain <= 8'd0; blue_gain <= 8'd0; hue_amt <= 8'd0;
      sat_pct <= 8'd100; light_pct <= 8'd100; mode <= 8'd240;
      errors <= 0;
      adjusted_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_RED_GAIN:   red_gain <= cfg_data;
          REG_GREEN_GAIN: green_gain <= cfg_data;
          REG_BLUE_GAIN:  blue_gain <= cfg_data;
          REG_HUE:        hue_amt <= cfg_data;
          REG_SAT:        sat_pct <= cfg_data;
          REG_LIGHT:      light_pct <= cfg_data;
          REG_MODE:       mode <= cfg_data;
          default: ;
        endcase
      end
      if (pix_in.valid && pix_in.ready) begin
        it = '{pix_in.opcode, pix_in.in_red, pix_in.in_green, pix_in.in_blue,
               pix_in.in_alpha, pix_in.table_index, pix_in.table_value};
        case (it.op)
          OP_PIXEL:         adjusted_q.push_back(adjust_pixel(it));
          OP_LOAD_BRIGHT:   bright_lut[it.idx] = it.tval;
          OP_LOAD_CONTRAST: contrast_lut[it.idx] = it.tval;
          default: ;
        endcase
      end
      if (pix_out.valid && pix_out.ready) begin
        got = '{pix_out.out_red, pix_out.out_green, pix_out.out_blue, pix_out.out_alpha};
        if (adjusted_q.size() == 0) begin
          if (errors < 10) $display("%0t: unexpected pixel %h", $realtime, got);
          errors <= errors + 1;
        end else begin
          want = adjusted_q.pop_front();
          if (want !== got) begin
            if (errors < 10)
              $display("%0t: pixel mismatch exp r%h g%h b%h a%h got r%h g%h b%h a%h",
                       $realtime, want.r, want.g, want.b, want.a,
                       got.r, got.g, got.b, got.a);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

[dv/pixel_color_adjust_hsl_tb.sv]
// Stimulus and verdict for pixel_color_adjust_hsl: loads both tables, then runs directed
// and random pixels over several register settings and idle patterns. Uses pcah_scoreboard.
`timescale 1ns / 100ps
module pixel_color_adjust_hsl_tb import pcah_pkg::*;;

  localparam int WATCHDOG_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;
  int   errors, pending;
  int   send_idle_pct = 0;
  int   stall_pct = 0;
  int   hold_cycles = 0;
  int   quiet_cycles = 0;

  pcah_in_if  pix_in();
  pcah_out_if pix_out();

  always #4 clk = ~clk;

  pixel_color_adjust_hsl u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pixel_in(pix_in), .pixel_out(pix_out)
  );

  pcah_scoreboard u_checker (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pix_in(pix_in), .pix_out(pix_out), .errors(errors), .pending(pending)
  );

  // receiver: long hold-off when requested, otherwise random stalls
  initial pix_out.ready = 1'b0;
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      pix_out.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      pix_out.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_req(logic [1:0] op, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                          logic [7:0] a, logic [7:0] idx, logic [7:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      pix_in.valid = 1'b0;
      @(negedge clk);
    end
    pix_in.valid = 1'b1;
    pix_in.opcode = op;
    pix_in.in_red = r;
    pix_in.in_green = g;
    pix_in.in_blue = b;
    pix_in.in_alpha = a;
    pix_in.table_index = idx;
    pix_in.table_value = val;
    do @(posedge clk); while (!pix_in.ready);
    @(negedge clk);
  endtask

  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
    send_req(OP_PIXEL, r, g, b, a, 8'($urandom), 8'($urandom));
  endtask

  task automatic drain();
    pix_in.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [7:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic write_all(logic [7:0] rg, logic [7:0] gg, logic [7:0] bg, logic [7:0] hue,
                           logic [7:0] sat, logic [7:0] lgt, logic [7:0] md);
    write_reg(REG_RED_GAIN, rg);
    write_reg(REG_GREEN_GAIN, gg);
    write_reg(REG_BLUE_GAIN, bg);
    write_reg(REG_HUE, hue);
    write_reg(REG_SAT, sat);
    write_reg(REG_LIGHT, lgt);
    write_reg(REG_MODE, md);
  endtask

  initial begin
    logic [7:0] r, g, b;
    int sel;
    pix_in.valid = 1'b0;
    pix_in.opcode = OP_PIXEL;
    pix_in.in_red = '0;
    pix_in.in_green = '0;
    pix_in.in_blue = '0;
    pix_in.in_alpha = '0;
    pix_in.table_index = '0;
    pix_in.table_value = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // brightness maps into the lower quarter, so only those contrast entries are read;
    // contrast spreads them back over the full range
    for (int i = 0; i < 256; i++)
      send_req(OP_LOAD_BRIGHT, 8'd0, 8'd0, 8'd0, 8'd0, 8'(i), 8'(i >> 2));
    for (int i = 0; i < 64; i++)
      send_req(OP_LOAD_CONTRAST, 8'd0, 8'd0, 8'd0, 8'd0, 8'(i), 8'((i << 2) | (i >> 4)));

    // directed pixels and one unused opcode at reset settings
    send_pixel(8'd0, 8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd0, 8'd18);
    send_pixel(8'd0, 8'd255, 8'd0, 8'd90);
    send_pixel(8'd0, 8'd0, 8'd255, 8'd200);
    send_pixel(8'd255, 8'd255, 8'd0, 8'd1);
    send_pixel(8'd0, 8'd255, 8'd255, 8'd254);
    send_pixel(8'd255, 8'd0, 8'd255, 8'd128);
    send_pixel(8'd128, 8'd128, 8'd128, 8'd127);
    send_pixel(8'd200, 8'd100, 8'd50, 8'd64);
    send_req(OP_UNUSED, 8'hAA, 8'h55, 8'hFF, 8'h00, 8'h3C, 8'hC3);
    drain();
    // non-positive gain, over-range scales, colorize, negate, alpha forced
    write_all(8'h80, 8'h9C, 8'h9D, 8'd200, 8'd255, 8'd255, 8'h0F);
    write_reg(REG_SPARE, 8'h5A);
    send_pixel(8'd255, 8'd128, 8'd0, 8'd77);
    send_pixel(8'd10, 8'd250, 8'd130, 8'd33);
    drain();
    write_all(8'd127, 8'd100, 8'd50, 8'd255, 8'd0, 8'd0, 8'hFF);
    send_pixel(8'd255, 8'd128, 8'd0, 8'd77);
    send_pixel(8'd100, 8'd200, 8'd30, 8'd66);
    drain();
    write_all(8'd0, 8'd0, 8'd0, 8'd0, 8'd200, 8'd200, 8'h78);
    send_pixel(8'd250, 8'd20, 8'd120, 8'd9);
    send_pixel(8'd5, 8'd60, 8'd240, 8'd250);
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 76; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 76; end
        default: begin send_idle_pct = 23; stall_pct = 23; end
      endcase
      if (phase == 1)
        write_all(8'h9C, 8'd0, 8'd100, 8'd0, 8'd0, 8'd200, 8'h70);
      else
        write_all(8'($urandom_range(0, 200) - 100), 8'($urandom), 8'($urandom_range(0, 200) - 100),
                  8'($urandom), 8'($urandom_range(0, 200)), 8'($urandom_range(0, 255)),
                  8'($urandom));
      if (phase == 0) hold_cycles = 300;
      for (int k = 0; k < 32; k++) begin
        sel = $urandom_range(99);
        r = 8'($urandom); g = 8'($urandom); b = 8'($urandom);
        if (sel < 75)
          send_pixel(r, g, b, 8'($urandom));
        else if (sel < 85)
          send_pixel(r, r, r, 8'($urandom));
        else if (sel < 92)
          send_req(OP_LOAD_BRIGHT, r, g, b, 8'($urandom), 8'($urandom),
                   8'($urandom_range(63)));
        else if (sel < 98)
          send_req(OP_LOAD_CONTRAST, r, g, b, 8'($urandom), 8'($urandom), 8'($urandom));
        else
          send_req(OP_UNUSED, r, g, b, 8'($urandom), 8'($urandom), 8'($urandom));
      end
      drain();
    end

    if (errors == 0 && pending == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
